[src/assert_macros.svh]
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define DHI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DHI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dhi_pkg.sv]
// Types and constants of the dithered histogram increment block.
package dhi_pkg;

    localparam int MAX_CHANNELS_DEF = 4096;
    localparam int VALUE_BITS_DEF   = 16;

    localparam int CHANS_W  = 13;
    localparam int SCALE_W  = 5;
    localparam int RAW_W    = 16;
    localparam int RND_W    = 7;
    localparam int RIDX_W   = 12;
    localparam int COUNT_W  = 16;
    localparam int ONE_W    = 32;
    localparam int CMP_W    = 39;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CHANS_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 1'd1;

    localparam logic [CHANS_W-1:0] CHANS_RESET = 13'd4096;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd12;

    localparam logic [CMP_W-1:0] PCT_FULL = 39'd100;

    localparam int CMD_Q_DEPTH = 2;
    localparam int RSP_Q_DEPTH = 2;

    localparam logic REQ_INCR = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic              value_present;
        logic [RAW_W-1:0]  raw_value;
        logic [RND_W-1:0]  random_percent;
        logic [RIDX_W-1:0] read_index;
    } req_t;

    typedef struct packed {
        logic [CHANS_W-1:0] bin_index;
        logic [COUNT_W-1:0] bin_count;
        logic               was_counted;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_INCR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHANS_W-1:0] bin_index;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } st_t;

endpackage

[src/dhi_fifo.sv]
// Small register queue used between the stages of the histogram block.
module dhi_fifo #(
    parameter type T     = dhi_pkg::cmd_t,
    parameter int  DEPTH = dhi_pkg::CMD_Q_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);
    import dhi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[src/dhi_front.sv]
// Front end: maps each beat onto a channel and classifies it into a command.
`include "assert_macros.svh"

module dhi_front #(
    parameter int MAX_CHANNELS = dhi_pkg::MAX_CHANNELS_DEF,
    parameter int VALUE_BITS   = dhi_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  dhi_pkg::req_t                item,
    output logic                         stall,
    input  logic [dhi_pkg::CHANS_W-1:0]  chans_cfg,
    input  logic [dhi_pkg::SCALE_W-1:0]  scale_cfg,
    output logic                         cmd_push,
    output dhi_pkg::cmd_t                cmd,
    input  logic                         cmd_full
);
    import dhi_pkg::*;

    localparam int VB    = (VALUE_BITS < RAW_W) ? VALUE_BITS : RAW_W;
    localparam int POS_W = VB + CHANS_W;

    logic                 a_v_reg, a_v_next;
    req_t                 a_item_reg;
    logic [POS_W-1:0]     a_pos_reg;
    logic [CHANS_W-1:0]   a_chans_reg;

    logic [CHANS_W-1:0]   chans_eff;
    logic [VB-1:0]        raw_m;
    logic [ONE_W-1:0]     one;
    logic [ONE_W-1:0]     frac;
    logic [POS_W-1:0]     whole;
    logic [CMP_W-1:0]     lhs, rhs;
    logic [POS_W:0]       chan;

    // stage A: effective channel count and the product
    assign chans_eff = (32'(chans_cfg) > 32'(MAX_CHANNELS)) ? CHANS_W'(MAX_CHANNELS)
                                                            : chans_cfg;
    assign raw_m     = item.raw_value[VB-1:0];

    always_comb
    begin
        a_v_next = a_v_reg;
        if (take)
        begin
            a_v_next = 1'b1;
        end
        else if (cmd_push)
        begin
            a_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_item_reg  <= item;
            a_pos_reg   <= POS_W'(raw_m) * POS_W'(chans_eff);
            a_chans_reg <= chans_eff;
        end
    end

    // stage B: split fixed point, dithered round up, range check
    assign one   = ONE_W'(1) << scale_cfg;
    assign frac  = ONE_W'(a_pos_reg) & (one - 1'b1);
    assign whole = a_pos_reg >> scale_cfg;
    assign lhs   = CMP_W'(one - frac) * PCT_FULL;
    assign rhs   = CMP_W'(a_item_reg.random_percent) << scale_cfg;
    assign chan  = (POS_W + 1)'(whole) + (POS_W + 1)'(lhs <= rhs);

    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.bin_index = '0;
        if (a_item_reg.req_type == REQ_READ)
        begin
            cmd.bin_index = CHANS_W'(a_item_reg.read_index);
            if (32'(a_item_reg.read_index) < 32'(MAX_CHANNELS))
            begin
                cmd.op = OP_READ;
            end
        end
        else if (a_item_reg.value_present)
        begin
            if (chan < (POS_W + 1)'(a_chans_reg))
            begin
                cmd.op        = OP_INCR;
                cmd.bin_index = CHANS_W'(chan);
            end
            else
            begin
                cmd.bin_index = a_chans_reg;
            end
        end
    end

    assign cmd_push = a_v_reg && !cmd_full;
    assign stall    = a_v_reg && cmd_full;

    `DHI_ASSERT(a_no_push_full, clk, rst_n, cmd_push |-> !cmd_full, "command pushed into full queue")
    `DHI_ASSERT(a_take_free, clk, rst_n, take |-> !stall, "beat taken while front end stalled")

endmodule

[src/dhi_back.sv]
// Back end: clears the count memory, reads the count of each command and writes back increments.
`include "assert_macros.svh"

module dhi_back #(
    parameter int MAX_CHANNELS = dhi_pkg::MAX_CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dhi_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output logic          rsp_push,
    output dhi_pkg::rsp_t rsp,
    input  logic          rsp_full,
    output logic          clearing
);
    import dhi_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHANNELS);

    st_t                 st_reg, st_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    cmd_t                cur_reg;
    logic [COUNT_W-1:0]  rd_data_reg;
    logic [COUNT_W-1:0]  bin_mem_reg [MAX_CHANNELS];

    logic                mem_rd, mem_we;
    logic [IDX_W-1:0]    raddr, waddr;
    logic [COUNT_W-1:0]  wdata;
    logic [COUNT_W-1:0]  bumped;

    assign raddr  = IDX_W'(cmd.bin_index);
    assign bumped = rd_data_reg + 1'b1;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(MAX_CHANNELS - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty && !rsp_full)
                begin
                    st_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop  = 1'b0;
        mem_rd   = 1'b0;
        mem_we   = 1'b0;
        waddr    = clr_reg;
        wdata    = '0;
        rsp_push = 1'b0;
        rsp      = '0;
        clearing = 1'b0;
        clr_next = clr_reg;
        unique case (st_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                cmd_pop = !cmd_empty && !rsp_full;
                mem_rd  = cmd_pop;
            end
            ST_LOOKUP:
            begin
                rsp_push      = 1'b1;
                rsp.bin_index = cur_reg.bin_index;
                waddr         = IDX_W'(cur_reg.bin_index);
                unique case (cur_reg.op)
                    OP_READ:
                    begin
                        rsp.bin_count = rd_data_reg;
                    end
                    OP_INCR:
                    begin
                        mem_we          = 1'b1;
                        wdata           = bumped;
                        rsp.bin_count   = bumped;
                        rsp.was_counted = 1'b1;
                    end
                    default:
                    begin
                        rsp.bin_count = '0;
                    end
                endcase
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_CLEAR;
            clr_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem_reg[waddr] <= wdata;
        end
        if (mem_rd)
        begin
            rd_data_reg <= bin_mem_reg[raddr];
        end
    end

    `DHI_ASSERT(a_rsp_room, clk, rst_n, rsp_push |-> !rsp_full, "result pushed into full queue")
    `DHI_ASSERT(a_pop_lookup, clk, rst_n, cmd_pop |=> st_reg == ST_LOOKUP, "pop not followed by lookup")
    `DHI_ASSERT_ALWAYS(a_clear_quiet, clk, clearing |-> !cmd_pop && !rsp_push, "command handled during clear")
    `DHI_ASSERT(a_write_incr, clk, rst_n, (mem_we && st_reg == ST_LOOKUP) |-> cur_reg.op == OP_INCR, "count written for non-increment")

endmodule

[src/dithered_histogram_increment_core.sv]
// Top level of the dithered histogram increment block.
//
// Input channel: a req beat is taken at a rising edge with push high and full
// low. An increment beat maps raw_value onto channel raw*channels/2^scale with
// a dithered round up and bumps that 16-bit count; a read beat returns one count.
// Result channel: rsp holds the oldest result while empty is low; it is taken at
// a rising edge with pop high. Every beat gives exactly one result, in order.
// Path: a beat passes the front register, the command queue, the back-end
// lookup state and the result queue. The back end pops a new command only once
// the single-port count memory is done with the read and any write of the last.
// Config: cfg_we writes cfg_data to register cfg_index (0 channel count,
// 1 scale) at a rising edge; write only while no beat is in flight.
// Reset: channel count 4096, scale 12, and a clearing pass writes zero to each
// of the MAX_CHANNELS counts in the count memory while full stays high.
// A stalled receiver fills the two-beat result queue, the two-beat command
// queue and the front register; then full rises and input beats wait.
module dithered_histogram_increment_core #(
    parameter int MAX_CHANNELS = dhi_pkg::MAX_CHANNELS_DEF,
    parameter int VALUE_BITS   = dhi_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  dhi_pkg::req_t                   req,
    input  logic                            pop,
    output logic                            empty,
    output dhi_pkg::rsp_t                   rsp,
    input  logic                            cfg_we,
    input  logic [dhi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dhi_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dhi_pkg::*;

    logic [CHANS_W-1:0] chans_reg, chans_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;

    logic  take, front_stall, clearing;
    logic  cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t  cmd_in, cmd_out;
    logic  rsp_push, rsp_full;
    rsp_t  rsp_in;

    always_comb
    begin
        chans_next = chans_reg;
        scale_next = scale_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNELS: chans_next = cfg_data;
                CFG_SCALE:    scale_next = cfg_data[SCALE_W-1:0];
                default:      chans_next = chans_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_reg <= CHANS_RESET;
            scale_reg <= SCALE_RESET;
        end
        else
        begin
            chans_reg <= chans_next;
            scale_reg <= scale_next;
        end
    end

    assign full = clearing || front_stall;
    assign take = push && !full;

    dhi_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (req),
        .stall     (front_stall),
        .chans_cfg (chans_reg),
        .scale_cfg (scale_reg),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full)
    );

    dhi_fifo #(
        .T     (cmd_t),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    dhi_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .rsp_push  (rsp_push),
        .rsp       (rsp_in),
        .rsp_full  (rsp_full),
        .clearing  (clearing)
    );

    dhi_fifo #(
        .T     (rsp_t),
        .DEPTH (RSP_Q_DEPTH)
    ) u_rsp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .wdata (rsp_in),
        .full  (rsp_full),
        .pop   (pop),
        .rdata (rsp),
        .empty (empty)
    );

endmodule

[test/tb_top.sv]
// Self-checking testbench for the dithered histogram increment core.
module tb_top;
    import dhi_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT = 20000;
    localparam int PHASE_ITEMS = 160;
    localparam int BURST_ITEMS = 200;
    localparam int NUM_PHASES = 11;
    localparam longint unsigned PERCENT = 100;

    class bin_tracker;
        bit [COUNT_W-1:0] counts [MAX_CHANNELS_DEF];
        bit [CHANS_W-1:0] chans;
        bit [SCALE_W-1:0] scale;
        rsp_t pending_bins[$];
        int fails;
        int n_reads;
        int n_absent;
        int n_counted;
        int n_missed;

        function new();
            chans = CHANS_RESET;
            scale = SCALE_RESET;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_CHANNELS)
                chans = val;
            else
                scale = val[SCALE_W-1:0];
        endfunction

        // Expected result of one accepted input beat.
        function void log_event(req_t r);
            rsp_t e;
            longint unsigned eff;
            longint unsigned one;
            longint unsigned pos;
            longint unsigned whole;
            longint unsigned frac;
            longint unsigned pick;
            longint unsigned rnd;
            e = '0;
            if (r.req_type == REQ_READ)
            begin
                e.bin_index = CHANS_W'(r.read_index);
                e.bin_count = counts[r.read_index];
                n_reads++;
            end
            else if (!r.value_present)
                n_absent++;
            else
            begin
                eff = (chans > MAX_CHANNELS_DEF) ? 64'(MAX_CHANNELS_DEF) : 64'(chans);
                one = 64'd1 << scale;
                pos = 64'(r.raw_value);
                pos = pos * eff;
                whole = pos >> scale;
                frac = pos & (one - 64'd1);
                rnd = 64'(r.random_percent);
                pick = whole;
                if (PERCENT * (one - frac) <= rnd * one)
                    pick = whole + 64'd1;
                if (pick < eff)
                begin
                    counts[pick] = counts[pick] + 1'b1;
                    e.bin_index = pick[CHANS_W-1:0];
                    e.bin_count = counts[pick];
                    e.was_counted = 1'b1;
                    n_counted++;
                end
                else
                begin
                    e.bin_index = eff[CHANS_W-1:0];
                    n_missed++;
                end
            end
            pending_bins.push_back(e);
        endfunction

        function void match_result(rsp_t got);
            rsp_t want;
            if (pending_bins.size() == 0)
            begin
                $display("%0t: unexpected result beat: index %0d count %0d counted %0b",
                         $time, got.bin_index, got.bin_count, got.was_counted);
                fails++;
                return;
            end
            want = pending_bins.pop_front();
            if (got.bin_index !== want.bin_index)
            begin
                $display("%0t: bin_index expected %0d got %0d",
                         $time, want.bin_index, got.bin_index);
                fails++;
            end
            if (got.bin_count !== want.bin_count)
            begin
                $display("%0t: bin_count expected %0d got %0d (index %0d)",
                         $time, want.bin_count, got.bin_count, want.bin_index);
                fails++;
            end
            if (got.was_counted !== want.was_counted)
            begin
                $display("%0t: was_counted expected %0b got %0b (index %0d)",
                         $time, want.was_counted, got.was_counted, want.bin_index);
                fails++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    req_t req = '0;
    logic pop = 1'b0;
    logic empty;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bin_tracker sb = new();
    bit idle_on = 1'b0;
    bit hold_req = 1'b0;

    dithered_histogram_increment_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .pop       (pop),
        .empty     (empty),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_t make_req(logic kind, logic present, int raw, int rnd, int idx);
        req_t r;
        r.req_type = kind;
        r.value_present = present;
        r.raw_value = raw[RAW_W-1:0];
        r.random_percent = rnd[RND_W-1:0];
        r.read_index = idx[RIDX_W-1:0];
        return r;
    endfunction

    // Mostly in-range increments, some reads, absent values and wild positions.
    function automatic req_t random_req();
        req_t r;
        int kind;
        int lim;
        r = make_req(REQ_INCR, 1'b1, $urandom_range(0, 65535), $urandom_range(0, 99),
                     $urandom_range(0, 4095));
        kind = $urandom_range(0, 99);
        lim = (sb.chans > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : sb.chans;
        if (kind < 22)
        begin
            r.req_type = REQ_READ;
            if (kind < 16 && lim != 0)
                r.read_index = RIDX_W'($urandom_range(0, lim - 1));
        end
        else if (kind < 30)
            r.value_present = 1'b0;
        else if (kind < 80 && sb.scale < RAW_W)
            r.raw_value = RAW_W'($urandom_range(0, (1 << sb.scale) - 1));
        if ($urandom_range(0, 9) == 0)
            r.random_percent = RND_W'($urandom_range(100, 127));
        return r;
    endfunction

    task automatic send_beat(input req_t r);
        push <= 1'b1;
        req <= r;
        do @(posedge clk); while (full);
        sb.log_event(r);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (sb.pending_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        sb.set_reg(idx, val[CFG_DATA_W-1:0]);
    endtask

    task automatic configure(input int chans, input int scale);
        settle();
        write_reg(CFG_CHANNELS, chans);
        write_reg(CFG_SCALE, scale);
        cfg_we <= 1'b0;
    endtask

    // Result side: checks accepted beats, stalls in bursts, long hold on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.match_result(rsp);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        req_t directed[$];
        int phase_chans [NUM_PHASES];
        int phase_scale [NUM_PHASES];

        phase_chans = '{1, 4096, 0, 8191, 5000, 100, 4095, 2, 37, 1000, 3};
        phase_scale = '{0, 16, 12, 31, 12, 8, 16, 1, 6, 10, 20};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (full);

        // reset settings: 4096 channels, scale 12
        directed.push_back(make_req(REQ_READ, 1'b0, 0, 0, 0));
        directed.push_back(make_req(REQ_READ, 1'b1, 65535, 127, 4095));
        directed.push_back(make_req(REQ_INCR, 1'b0, 65535, 127, 4095));
        directed.push_back(make_req(REQ_INCR, 1'b1, 0, 0, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 0, 99, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 0, 100, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 4095, 0, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 4095, 127, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 65535, 0, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 4096, 50, 0));
        directed.push_back(make_req(REQ_READ, 1'b0, 0, 0, 0));
        directed.push_back(make_req(REQ_READ, 1'b0, 0, 0, 1));
        directed.push_back(make_req(REQ_READ, 1'b0, 0, 0, 4095));
        foreach (directed[i])
            send_beat(directed[i]);

        // 3 channels, scale 2: rounding boundaries of the dither
        configure(3, 2);
        directed.delete();
        directed.push_back(make_req(REQ_INCR, 1'b1, 1, 24, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 1, 25, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 3, 74, 0));
        directed.push_back(make_req(REQ_INCR, 1'b1, 3, 75, 0));
        directed.push_back(make_req(REQ_READ, 1'b0, 0, 0, 0));
        directed.push_back(make_req(REQ_READ, 1'b0, 0, 0, 1));
        directed.push_back(make_req(REQ_READ, 1'b0, 0, 0, 2));
        foreach (directed[i])
            send_beat(directed[i]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            configure(phase_chans[p], phase_scale[p]);
            idle_on = (p % 3 != 2);
            if (p == 1)
            begin
                idle_on = 1'b0;
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_beat(random_req());
        end

        // back to back on one channel
        idle_on = 1'b0;
        configure(1, 16);
        repeat (BURST_ITEMS) send_beat(make_req(REQ_INCR, 1'b1, 0, 0, 0));
        send_beat(make_req(REQ_READ, 1'b0, 0, 0, 0));
        settle();

        $display("beats: %0d counted, %0d out of range, %0d absent, %0d reads",
                 sb.n_counted, sb.n_missed, sb.n_absent, sb.n_reads);
        $display("swept channel counts 0..8191, scales 0..31, long result hold, gapless burst");
        if (sb.fails == 0 && sb.pending_bins.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[dithered_histogram_increment_core.f]
+incdir+src
src/dhi_pkg.sv
src/dhi_fifo.sv
src/dhi_front.sv
src/dhi_back.sv
src/dithered_histogram_increment_core.sv
test/tb_top.sv
